### design/isc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isc_pkg;

    // Geometry and transfer size defaults.
    localparam int ISC_SECTOR_BYTES   = 256;
    localparam int ISC_IDENTIFY_BYTES = 512;
    localparam int ISC_BPT_DIVISOR    = 254;

    // Fixed data and status codes.
    localparam logic [7:0] IDENT_FILL   = 8'h5A;
    localparam logic [7:0] STATUS_READY = 8'h40;
    localparam logic [7:0] STATUS_DONE  = 8'h50;
    localparam logic [15:0] LEFT_MAX    = 16'hFFFF;

    // Opcode defaults after reset.
    localparam logic [7:0] OPC_IDENTIFY_RST = 8'd236;
    localparam logic [7:0] OPC_READ_RST     = 8'd32;
    localparam logic [7:0] OPC_WRITE_RST    = 8'd48;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SPT_DISK0    = 3'd0,
        CFG_SPT_DISK1    = 3'd1,
        CFG_OPC_IDENTIFY = 3'd2,
        CFG_OPC_READ     = 3'd3,
        CFG_OPC_WRITE    = 3'd4
    } t_cfg_index;

    // Task file addresses (low three bits, upper bits zero).
    typedef enum logic [2:0] {
        ADDR_DATA       = 3'd0,
        ADDR_ERROR      = 3'd1,
        ADDR_SECT_COUNT = 3'd2,
        ADDR_SECT_NUM   = 3'd3,
        ADDR_CYL_LOW    = 3'd4,
        ADDR_CYL_HIGH   = 3'd5,
        ADDR_DRIVE_HEAD = 3'd6,
        ADDR_COMMAND    = 3'd7
    } t_addr;

    // What the last pipeline stage has to do with a request.
    typedef enum logic [2:0] {
        KIND_DATA,
        KIND_COMMAND,
        KIND_DRIVE_HEAD,
        KIND_STATUS,
        KIND_OTHER
    } t_kind;

    // Request as it travels down the pipeline.
    typedef struct packed {
        logic        is_write;
        t_kind       kind;
        logic [7:0]  wval;
        logic [7:0]  dbyte;
        logic [7:0]  rval;
        logic        disk;
        logic [15:0] len;
    } t_item;

endpackage

`default_nettype wire

### design/ide_sector_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted request passes stages s1, s2, s3 and s4, then the result register.
// Throughput: one bus request per cycle while o_stall is low; the block-number divide
// and the offset multiply run in three pipeline stages ahead of the transfer state update.
// Reset: synchronous, active low; task file cleared, status 0x40, identify transfer
// of full length armed, opcodes back to their defaults, pipeline emptied.
module ide_sector_controller
    import isc_pkg::*;
#(
    parameter int SECTOR_BYTES             = ISC_SECTOR_BYTES,
    parameter int IDENTIFY_BYTES           = ISC_IDENTIFY_BYTES,
    parameter int BLOCKS_PER_TRACK_DIVISOR = ISC_BPT_DIVISOR
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_wdata,
    // Request channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_op,
    input  wire logic [15:0] i_reg_address,
    input  wire logic [7:0]  i_write_value,
    input  wire logic [7:0]  i_disk_byte,
    // Result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_read_value,
    output logic             o_access_disk,
    output logic [31:0]      o_access_offset,
    output logic             o_disk_read_taken,
    output logic             o_disk_write_strobe,
    output logic [31:0]      o_next_offset,
    output logic [15:0]      o_bytes_remaining
);

    localparam int SB_W   = $clog2(SECTOR_BYTES + 1);
    localparam int LEN_W  = SB_W + 8;
    localparam int SPTB_W = SB_W + 8;
    localparam int BLK_W  = 24;
    localparam logic [31:0] RECIP = 32'(64'hFFFF_FFFF / BLOCKS_PER_TRACK_DIVISOR);
    localparam logic [BLK_W-1:0] DIV_C = BLK_W'(BLOCKS_PER_TRACK_DIVISOR);
    localparam logic [15:0] IDENT_LEN = 16'(IDENTIFY_BYTES);

    // Configuration; sectors per track is kept pre-scaled by the sector size.
    logic [SPTB_W-1:0] r_sptb0, r_sptb1;
    logic [7:0]        r_opc_ident, r_opc_read, r_opc_write;

    // Task file (the feature register has no effect and is not stored).
    logic [7:0] r_sect_count, r_sect_num, r_cyl_low, r_cyl_high, r_drive_head;

    // Transfer state, owned by the last stage.
    logic [7:0]  r_status, r_command;
    logic [31:0] r_pos;
    logic [15:0] r_left;
    logic        r_from_ident, r_disk;

    // Pipeline stages.
    logic             r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_out_vld;
    t_item            r_s1_item, r_s2_item, r_s3_item, r_s4_item;
    logic [BLK_W-1:0] r_s1_block, r_s2_block, r_s2_quot, r_s3_track;
    logic [7:0]       r_s3_sector;
    logic [31:0]      r_s4_start;

    // Result register.
    logic [7:0]  r_out_rval;
    logic        r_out_disk, r_out_taken, r_out_strobe;
    logic [31:0] r_out_acc_off, r_out_next_off;
    logic [15:0] r_out_left;

    // Stall chain: a stage loads when it is empty or its content moves on.
    logic ld_out, ld4, ld3, ld2, ld1, acc;

    assign ld_out  = !r_out_vld || !i_stall;
    assign ld4     = !r_s4_vld || ld_out;
    assign ld3     = !r_s3_vld || ld4;
    assign ld2     = !r_s2_vld || ld3;
    assign ld1     = !r_s1_vld || ld2;
    assign o_stall = !ld1;
    assign acc     = i_valid && ld1;

    // Decode of the incoming request against the current task file.
    logic             addr_hi_zero;
    t_addr            addr_lo;
    t_item            n_item;
    logic [LEN_W-1:0] len_full;

    assign addr_hi_zero = (i_reg_address[15:3] == 13'd0);
    assign addr_lo      = t_addr'(i_reg_address[2:0]);
    assign len_full     = LEN_W'(r_sect_count) * LEN_W'(SECTOR_BYTES);

    always_comb begin
        n_item.is_write = i_op;
        n_item.wval     = i_write_value;
        n_item.dbyte    = i_disk_byte;
        n_item.disk     = r_drive_head[4];
        n_item.len      = (len_full > LEN_W'(LEFT_MAX)) ? LEFT_MAX : len_full[15:0];
        n_item.kind     = KIND_OTHER;
        n_item.rval     = 8'd0;
        if (addr_hi_zero) begin
            unique case (addr_lo)
                ADDR_DATA:       n_item.kind = KIND_DATA;
                ADDR_COMMAND:    n_item.kind = i_op ? KIND_COMMAND : KIND_STATUS;
                ADDR_DRIVE_HEAD: begin
                    n_item.kind = i_op ? KIND_DRIVE_HEAD : KIND_OTHER;
                    n_item.rval = r_drive_head;
                end
                ADDR_SECT_COUNT: n_item.rval = r_sect_count;
                ADDR_SECT_NUM:   n_item.rval = r_sect_num;
                ADDR_CYL_LOW:    n_item.rval = r_cyl_low;
                ADDR_CYL_HIGH:   n_item.rval = r_cyl_high;
                default:         n_item.rval = 8'd0;
            endcase
        end
    end

    // Configuration and task file writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sptb0      <= '0;
            r_sptb1      <= '0;
            r_opc_ident  <= OPC_IDENTIFY_RST;
            r_opc_read   <= OPC_READ_RST;
            r_opc_write  <= OPC_WRITE_RST;
            r_sect_count <= 8'd0;
            r_sect_num   <= 8'd0;
            r_cyl_low    <= 8'd0;
            r_cyl_high   <= 8'd0;
            r_drive_head <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_SPT_DISK0:    r_sptb0 <= SPTB_W'(i_cfg_wdata) * SPTB_W'(SECTOR_BYTES);
                    CFG_SPT_DISK1:    r_sptb1 <= SPTB_W'(i_cfg_wdata) * SPTB_W'(SECTOR_BYTES);
                    CFG_OPC_IDENTIFY: r_opc_ident <= i_cfg_wdata;
                    CFG_OPC_READ:     r_opc_read  <= i_cfg_wdata;
                    CFG_OPC_WRITE:    r_opc_write <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (acc && i_op && addr_hi_zero) begin
                unique case (addr_lo)
                    ADDR_SECT_COUNT: r_sect_count <= i_write_value;
                    ADDR_SECT_NUM:   r_sect_num   <= i_write_value;
                    ADDR_CYL_LOW:    r_cyl_low    <= i_write_value;
                    ADDR_CYL_HIGH:   r_cyl_high   <= i_write_value;
                    ADDR_DRIVE_HEAD: r_drive_head <= i_write_value;
                    default: ;
                endcase
            end
        end
    end

    // Quotient estimate by reciprocal; it is exact or one short.
    logic [BLK_W+31:0] quot_prod;
    assign quot_prod = (BLK_W + 32)'(r_s1_block) * (BLK_W + 32)'(RECIP);

    // Remainder and single correction step.
    logic [BLK_W-1:0] rem0;
    logic             rem_big;
    assign rem0    = r_s2_block - r_s2_quot * DIV_C;
    assign rem_big = (rem0 >= DIV_C);

    // Start offset = track * spt * sector_bytes + sector * sector_bytes.
    logic [31:0] start_off;
    assign start_off = 32'(r_s3_track) * 32'(r_s3_item.disk ? r_sptb1 : r_sptb0)
                     + 32'(r_s3_sector) * 32'(SECTOR_BYTES);

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (ld1)    r_s1_vld  <= acc;
            if (ld2)    r_s2_vld  <= r_s1_vld;
            if (ld3)    r_s3_vld  <= r_s2_vld;
            if (ld4)    r_s4_vld  <= r_s3_vld;
            if (ld_out) r_out_vld <= r_s4_vld;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_s1_item  <= n_item;
            r_s1_block <= {r_cyl_high, r_cyl_low, r_sect_num};
        end
        if (ld2) begin
            r_s2_item  <= r_s1_item;
            r_s2_block <= r_s1_block;
            r_s2_quot  <= quot_prod[BLK_W+31:32];
        end
        if (ld3) begin
            r_s3_item   <= r_s2_item;
            r_s3_track  <= rem_big ? r_s2_quot + BLK_W'(1) : r_s2_quot;
            r_s3_sector <= rem_big ? 8'(rem0 - DIV_C) : 8'(rem0);
        end
        if (ld4) begin
            r_s4_item  <= r_s3_item;
            r_s4_start <= start_off;
        end
    end

    // Last stage: transfer state update and result forming.
    logic [7:0]  n_status, n_command, res_rval;
    logic [31:0] n_pos, res_acc_off;
    logic [15:0] n_left;
    logic        n_from_ident, n_disk, res_taken, res_strobe;
    logic        data_ok, moved;

    always_comb begin
        n_status     = r_status;
        n_command    = r_command;
        n_pos        = r_pos;
        n_left       = r_left;
        n_from_ident = r_from_ident;
        n_disk       = r_disk;
        res_rval     = r_s4_item.rval;
        res_acc_off  = 32'd0;
        res_taken    = 1'b0;
        res_strobe   = 1'b0;
        data_ok      = 1'b0;
        moved        = 1'b0;
        case (r_s4_item.kind)
            KIND_DATA: begin
                if (r_s4_item.is_write) begin
                    data_ok = (r_command == r_opc_write);
                end else begin
                    data_ok = (r_command == r_opc_ident) || (r_command == r_opc_read);
                end
                moved    = data_ok && (r_left != 16'd0);
                res_rval = 8'd0;
                if (moved) begin
                    res_acc_off = r_pos;
                    n_pos       = r_pos + 32'd1;
                    n_left      = r_left - 16'd1;
                    if (!r_s4_item.is_write) begin
                        res_rval  = r_from_ident ? IDENT_FILL : r_s4_item.dbyte;
                        res_taken = !r_from_ident;
                    end else begin
                        res_strobe = !r_from_ident;
                    end
                end
                // Transfer used up, either now or before.
                if (data_ok && (n_left == 16'd0)) begin
                    n_status = STATUS_DONE;
                end
            end
            KIND_COMMAND: begin
                n_command = r_s4_item.wval;
                n_disk    = r_s4_item.disk;
                if (r_s4_item.wval == r_opc_ident) begin
                    n_pos        = 32'd0;
                    n_left       = IDENT_LEN;
                    n_from_ident = 1'b1;
                end else if ((r_s4_item.wval == r_opc_read) ||
                             (r_s4_item.wval == r_opc_write)) begin
                    n_pos        = r_s4_start;
                    n_left       = r_s4_item.len;
                    n_from_ident = 1'b0;
                end
            end
            KIND_DRIVE_HEAD: n_status = STATUS_DONE;
            KIND_STATUS:     res_rval = r_status;
            default: ;
        endcase
        if (r_s4_item.is_write) begin
            res_rval = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status     <= STATUS_READY;
            r_command    <= 8'd0;
            r_pos        <= 32'd0;
            r_left       <= IDENT_LEN;
            r_from_ident <= 1'b1;
            r_disk       <= 1'b0;
        end else if (ld_out && r_s4_vld) begin
            r_status     <= n_status;
            r_command    <= n_command;
            r_pos        <= n_pos;
            r_left       <= n_left;
            r_from_ident <= n_from_ident;
            r_disk       <= n_disk;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_rval     <= res_rval;
            r_out_disk     <= n_disk;
            r_out_acc_off  <= res_acc_off;
            r_out_taken    <= res_taken;
            r_out_strobe   <= res_strobe;
            r_out_next_off <= n_pos;
            r_out_left     <= n_left;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_read_value        = r_out_rval;
    assign o_access_disk       = r_out_disk;
    assign o_access_offset     = r_out_acc_off;
    assign o_disk_read_taken   = r_out_taken;
    assign o_disk_write_strobe = r_out_strobe;
    assign o_next_offset       = r_out_next_off;
    assign o_bytes_remaining   = r_out_left;

endmodule

`default_nettype wire

### dv/ide_sector_controller_tb.sv
`timescale 1ns / 1ps

module ide_sector_controller_tb;
    import isc_pkg::*;

    localparam int   PIPE_LATENCY = 5;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam logic OP_READ      = 1'b0;
    localparam logic OP_WRITE     = 1'b1;

    // One bus result, in the order of the result ports.
    typedef struct packed {
        logic [7:0]  read_value;
        logic        access_disk;
        logic [31:0] access_offset;
        logic        read_taken;
        logic        write_strobe;
        logic [31:0] next_offset;
        logic [15:0] bytes_remaining;
    } t_bus_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_op = 1'b0;
    logic [15:0] i_reg_address = '0;
    logic [7:0]  i_write_value = '0;
    logic [7:0]  i_disk_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_read_value;
    logic        o_access_disk;
    logic [31:0] o_access_offset;
    logic        o_disk_read_taken;
    logic        o_disk_write_strobe;
    logic [31:0] o_next_offset;
    logic [15:0] o_bytes_remaining;

    ide_sector_controller i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_op                (i_op),
        .i_reg_address       (i_reg_address),
        .i_write_value       (i_write_value),
        .i_disk_byte         (i_disk_byte),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_read_value        (o_read_value),
        .o_access_disk       (o_access_disk),
        .o_access_offset     (o_access_offset),
        .o_disk_read_taken   (o_disk_read_taken),
        .o_disk_write_strobe (o_disk_write_strobe),
        .o_next_offset       (o_next_offset),
        .o_bytes_remaining   (o_bytes_remaining)
    );

    // Predictor copy of the configuration registers.
    logic [7:0] cfg_spt0, cfg_spt1, cfg_opc_ident, cfg_opc_read, cfg_opc_write;

    // Predictor copy of the task file and the transfer state.
    logic [7:0]  tf_sect_count, tf_sect_num, tf_cyl_low, tf_cyl_high;
    logic [7:0]  tf_drive_head, tf_status, tf_command;
    logic [31:0] xfer_pos;
    logic [15:0] xfer_left;
    logic        xfer_ident;
    logic        xfer_disk;

    t_bus_result expected_results[$];
    int          error_count = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    int          rx_hold = 0;
    logic        idle_on = 1'b1;

    // Clock generation.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // State of the task file right after reset.
    function automatic void reset_task_file();
        cfg_spt0      = '0;
        cfg_spt1      = '0;
        cfg_opc_ident = OPC_IDENTIFY_RST;
        cfg_opc_read  = OPC_READ_RST;
        cfg_opc_write = OPC_WRITE_RST;
        tf_sect_count = '0;
        tf_sect_num   = '0;
        tf_cyl_low    = '0;
        tf_cyl_high   = '0;
        tf_drive_head = '0;
        tf_status     = STATUS_READY;
        tf_command    = '0;
        xfer_pos      = '0;
        xfer_left     = 16'(ISC_IDENTIFY_BYTES);
        xfer_ident    = 1'b1;
        xfer_disk     = 1'b0;
    endfunction

    // A command write latches the disk and may arm a new transfer.
    function automatic void start_transfer();
        logic [23:0] blk;
        logic [31:0] track, sect, len;
        logic [7:0]  spt;
        logic [63:0] lba;
        xfer_disk = tf_drive_head[4];
        if (tf_command == cfg_opc_ident) begin
            xfer_pos   = '0;
            xfer_left  = 16'(ISC_IDENTIFY_BYTES);
            xfer_ident = 1'b1;
        end else if (tf_command == cfg_opc_read || tf_command == cfg_opc_write) begin
            blk   = {tf_cyl_high, tf_cyl_low, tf_sect_num};
            track = 32'(blk) / 32'(ISC_BPT_DIVISOR);
            sect  = 32'(blk) % 32'(ISC_BPT_DIVISOR);
            spt   = xfer_disk ? cfg_spt1 : cfg_spt0;
            lba   = 64'(track) * 64'(spt) + 64'(sect);
            // The byte offset wraps modulo 2^32.
            xfer_pos   = 32'(lba * 64'(ISC_SECTOR_BYTES));
            len        = 32'(ISC_SECTOR_BYTES) * 32'(tf_sect_count);
            xfer_left  = (len > 32'(LEFT_MAX)) ? LEFT_MAX : len[15:0];
            xfer_ident = 1'b0;
        end
    endfunction

    // Predict the result of one bus request and advance the predictor state.
    function automatic t_bus_result predict_access(logic op, logic [15:0] addr,
                                                   logic [7:0] wval, logic [7:0] dbyte);
        t_bus_result r;
        logic        active;
        logic [7:0]  rval;
        r    = '0;
        rval = '0;
        if (addr == 16'd0) begin
            // Data register: only moves a byte when the command allows this direction.
            active = op ? (tf_command == cfg_opc_write)
                        : (tf_command == cfg_opc_ident || tf_command == cfg_opc_read);
            if (active) begin
                if (xfer_left != 16'd0) begin
                    r.access_offset = xfer_pos;
                    if (!op) begin
                        if (xfer_ident) begin
                            rval = IDENT_FILL;
                        end else begin
                            rval         = dbyte;
                            r.read_taken = 1'b1;
                        end
                    end else if (!xfer_ident) begin
                        r.write_strobe = 1'b1;
                    end
                    xfer_pos  = xfer_pos + 32'd1;
                    xfer_left = xfer_left - 16'd1;
                end
                if (xfer_left == 16'd0) tf_status = STATUS_DONE;
            end
        end else if (addr[15:3] == '0) begin
            if (op) begin
                case (t_addr'(addr[2:0]))
                    ADDR_SECT_COUNT: tf_sect_count = wval;
                    ADDR_SECT_NUM:   tf_sect_num = wval;
                    ADDR_CYL_LOW:    tf_cyl_low = wval;
                    ADDR_CYL_HIGH:   tf_cyl_high = wval;
                    ADDR_DRIVE_HEAD: begin
                        tf_drive_head = wval;
                        tf_status     = STATUS_DONE;
                    end
                    ADDR_COMMAND: begin
                        tf_command = wval;
                        start_transfer();
                    end
                    // The feature register has no visible effect.
                    default: ;
                endcase
            end else begin
                case (t_addr'(addr[2:0]))
                    ADDR_SECT_COUNT: rval = tf_sect_count;
                    ADDR_SECT_NUM:   rval = tf_sect_num;
                    ADDR_CYL_LOW:    rval = tf_cyl_low;
                    ADDR_CYL_HIGH:   rval = tf_cyl_high;
                    ADDR_DRIVE_HEAD: rval = tf_drive_head;
                    ADDR_COMMAND:    rval = tf_status;
                    // The error register always reads as zero.
                    default:         rval = '0;
                endcase
            end
        end
        r.read_value      = op ? 8'd0 : rval;
        r.access_disk     = xfer_disk;
        r.next_offset     = xfer_pos;
        r.bytes_remaining = xfer_left;
        return r;
    endfunction

    // Print one mismatch line, keeping the log short on a badly broken block.
    task automatic flag_error(string msg);
        if (error_count < 40) $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) flag_error($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    endtask

    // Predict every accepted request and check every accepted result in order.
    always @(posedge i_clk) begin : bus_monitor
        t_bus_result got;
        t_bus_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(predict_access(i_op, i_reg_address,
                                                          i_write_value, i_disk_byte));
            end
            if (o_valid && !i_stall) begin
                got = {o_read_value, o_access_disk, o_access_offset, o_disk_read_taken,
                       o_disk_write_strobe, o_next_offset, o_bytes_remaining};
                if (expected_results.size() == 0) begin
                    flag_error("result with no request outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_value", 32'(want.read_value), 32'(got.read_value));
                    check_field("access_disk", 32'(want.access_disk), 32'(got.access_disk));
                    check_field("access_offset", want.access_offset, got.access_offset);
                    check_field("disk_read_taken", 32'(want.read_taken),
                                32'(got.read_taken));
                    check_field("disk_write_strobe", 32'(want.write_strobe),
                                32'(got.write_strobe));
                    check_field("next_offset", want.next_offset, got.next_offset);
                    check_field("bytes_remaining", 32'(want.bytes_remaining),
                                32'(got.bytes_remaining));
                end
            end
        end
    end

    // Result-side backpressure comes in random bursts.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(1, 6);
        end
        i_stall <= (rx_hold > 0);
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** ide_sector_controller: FAILED **");
            $finish;
        end
    end

    // Present one request and hold it until it is accepted.
    task automatic send_access(logic op, logic [15:0] addr, logic [7:0] wval,
                               logic [7:0] dbyte);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_op          <= op;
        i_reg_address <= addr;
        i_write_value <= wval;
        i_disk_byte   <= dbyte;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic send_write(t_addr a, logic [7:0] val);
        send_access(OP_WRITE, 16'(a), val, 8'($urandom));
    endtask

    task automatic send_read(t_addr a, logic [7:0] dbyte);
        send_access(OP_READ, 16'(a), 8'($urandom), dbyte);
    endtask

    // Let every outstanding request come out, then idle past the pipeline depth.
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic write_config(t_cfg_index idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_SPT_DISK0:    cfg_spt0 = val;
            CFG_SPT_DISK1:    cfg_spt1 = val;
            CFG_OPC_IDENTIFY: cfg_opc_ident = val;
            CFG_OPC_READ:     cfg_opc_read = val;
            CFG_OPC_WRITE:    cfg_opc_write = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Reprogram all five registers while the block is idle.
    task automatic apply_config(logic [7:0] spt0, logic [7:0] spt1, logic [7:0] ident,
                                logic [7:0] rd, logic [7:0] wr);
        drain_pipeline();
        write_config(CFG_SPT_DISK0, spt0);
        write_config(CFG_SPT_DISK1, spt1);
        write_config(CFG_OPC_IDENTIFY, ident);
        write_config(CFG_OPC_READ, rd);
        write_config(CFG_OPC_WRITE, wr);
    endtask

    // Set up the task file, issue a command, then move data through it.
    task automatic run_command_flow();
        logic [7:0] count, cmd;
        logic       rd_ok, wr_ok, data_op;
        int         pick, xfer_len, n_data;
        pick  = $urandom_range(0, 9);
        count = (pick < 7) ? 8'($urandom_range(0, 2)) : 8'($urandom);
        send_write(ADDR_SECT_COUNT, count);
        send_write(ADDR_SECT_NUM, 8'($urandom));
        send_write(ADDR_CYL_LOW, 8'($urandom));
        send_write(ADDR_CYL_HIGH, 8'($urandom));
        send_write(ADDR_DRIVE_HEAD, 8'($urandom));
        if ($urandom_range(0, 3) == 0) send_write(ADDR_ERROR, 8'($urandom));
        case ($urandom_range(0, 9))
            0, 1, 2: cmd = cfg_opc_ident;
            3, 4, 5: cmd = cfg_opc_read;
            6, 7, 8: cmd = cfg_opc_write;
            default: cmd = 8'($urandom);
        endcase
        send_write(ADDR_COMMAND, cmd);

        // Work out the transfer length and the direction the command accepts.
        rd_ok = (cmd == cfg_opc_ident || cmd == cfg_opc_read);
        wr_ok = (cmd == cfg_opc_write);
        if (cmd == cfg_opc_ident) xfer_len = ISC_IDENTIFY_BYTES;
        else if (rd_ok || wr_ok) xfer_len = ISC_SECTOR_BYTES * count;
        else xfer_len = 0;
        if (rd_ok && wr_ok) data_op = 1'($urandom_range(0, 1));
        else if (wr_ok) data_op = OP_WRITE;
        else if (rd_ok) data_op = OP_READ;
        else data_op = 1'($urandom_range(0, 1));

        // Sometimes run past the end of the transfer, mostly stop early.
        if ($urandom_range(0, 3) == 0 && xfer_len <= ISC_IDENTIFY_BYTES)
            n_data = xfer_len + $urandom_range(1, 3);
        else
            n_data = $urandom_range(1, 24);

        for (int i = 0; i < n_data; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 17)
                send_access(data_op, 16'(ADDR_DATA), 8'($urandom), 8'($urandom));
            else if (pick == 17)
                send_access(~data_op, 16'(ADDR_DATA), 8'($urandom), 8'($urandom));
            else if (pick == 18)
                send_read(t_addr'($urandom_range(1, 7)), 8'($urandom));
            else
                send_access(1'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
        end
        send_read(ADDR_COMMAND, 8'($urandom));
    endtask

    // Mostly command flows, with bursts of unstructured requests mixed in.
    task automatic run_traffic(int n);
        int stop_at;
        int burst;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 8);
                repeat (burst) begin
                    if ($urandom_range(0, 1) == 0)
                        send_access(1'($urandom), 16'($urandom_range(0, 7)),
                                    8'($urandom), 8'($urandom));
                    else
                        send_access(1'($urandom), 16'($urandom), 8'($urandom),
                                    8'($urandom));
                end
            end else begin
                run_command_flow();
            end
        end
    endtask

    // Reads of every register straight out of reset, plus unused addresses.
    task automatic test_reset_defaults();
        for (int a = ADDR_ERROR; a <= ADDR_COMMAND; a++) send_read(t_addr'(a), 8'hA5);
        send_read(ADDR_DATA, 8'hFF);
        send_access(OP_READ, 16'hFFFF, 8'h00, 8'h00);
        send_access(OP_WRITE, 16'h0008, 8'hFF, 8'hFF);
    endtask

    // Drive/head write sets done status; identify streams the fill pattern.
    task automatic test_identify_status();
        send_write(ADDR_DRIVE_HEAD, 8'h00);
        send_read(ADDR_COMMAND, 8'h00);
        send_write(ADDR_COMMAND, cfg_opc_ident);
        send_read(ADDR_DATA, 8'h00);
        send_read(ADDR_DATA, 8'hFF);
        send_access(OP_WRITE, 16'(ADDR_DATA), 8'hFF, 8'h00);
    endtask

    // Largest block on disk one with the widest geometry, then an empty transfer.
    task automatic test_sector_extremes();
        apply_config(8'hFF, 8'hFF, OPC_IDENTIFY_RST, OPC_READ_RST, OPC_WRITE_RST);
        send_write(ADDR_SECT_COUNT, 8'hFF);
        send_write(ADDR_SECT_NUM, 8'hFF);
        send_write(ADDR_CYL_LOW, 8'hFF);
        send_write(ADDR_CYL_HIGH, 8'hFF);
        send_write(ADDR_DRIVE_HEAD, 8'hFF);
        send_write(ADDR_COMMAND, cfg_opc_read);
        send_read(ADDR_DATA, 8'hFF);
        send_write(ADDR_COMMAND, cfg_opc_write);
        send_access(OP_WRITE, 16'(ADDR_DATA), 8'hFF, 8'h00);
        send_write(ADDR_SECT_COUNT, 8'h00);
        send_write(ADDR_COMMAND, cfg_opc_read);
        send_read(ADDR_DATA, 8'h5A);
    endtask

    task automatic test_default_opcodes();
        apply_config(8'($urandom), 8'($urandom), OPC_IDENTIFY_RST, OPC_READ_RST,
                     OPC_WRITE_RST);
        run_traffic(350);
    endtask

    task automatic test_geometry_extremes();
        apply_config(8'h00, 8'hFF, OPC_IDENTIFY_RST, OPC_READ_RST, OPC_WRITE_RST);
        run_traffic(175);
        apply_config(8'hFF, 8'h00, OPC_IDENTIFY_RST, OPC_READ_RST, OPC_WRITE_RST);
        run_traffic(175);
    endtask

    // Coinciding opcodes: identify must win over read and write.
    task automatic test_opcode_overlap();
        logic [7:0] opc;
        opc = 8'($urandom);
        apply_config(8'($urandom), 8'($urandom), opc, opc, opc);
        run_traffic(175);
        apply_config(8'($urandom), 8'($urandom), opc, opc + 8'd1, opc);
        run_traffic(175);
    endtask

    task automatic test_random_opcodes();
        apply_config(8'($urandom), 8'($urandom), 8'h00, 8'hFF, 8'($urandom));
        run_traffic(350);
    endtask

    // Final stretch with both sides running flat out.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        apply_config(8'($urandom), 8'($urandom), OPC_IDENTIFY_RST, OPC_READ_RST,
                     OPC_WRITE_RST);
        run_traffic(350);
    endtask

    initial begin
        reset_task_file();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_identify_status();
        test_sector_extremes();
        test_default_opcodes();
        test_geometry_extremes();
        test_opcode_overlap();
        test_random_opcodes();
        test_back_to_back();

        drain_pipeline();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("** ide_sector_controller: PASSED **");
        end else begin
            $display("** ide_sector_controller: FAILED **");
        end
        $finish;
    end

endmodule
